>>> hw/rtl/xkac_pkg.sv
// Shared types, constants and key helpers for the keystream archive codec.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
package xkac_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_KEY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENCODE_MODE = 1'b1;

  localparam logic [31:0] KEY_RESET = 32'hDEAD_CAFE;
  localparam logic [31:0] HDR_WORD0 = 32'h5353_4752;
  localparam logic [31:0] HDR_WORD1 = 32'h0100_4441;
  localparam logic [31:0] KEY_MUL = 32'd7;
  localparam logic [31:0] KEY_ADD = 32'd3;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  localparam logic [2:0] SEC_HDR = 3'd0;
  localparam logic [2:0] SEC_NLEN = 3'd1;
  localparam logic [2:0] SEC_NAME = 3'd2;
  localparam logic [2:0] SEC_CLEN = 3'd3;
  localparam logic [2:0] SEC_CONT = 3'd4;

  typedef enum logic [2:0] {
    PH_HDR  = 3'd0,
    PH_NLEN = 3'd1,
    PH_NAME = 3'd2,
    PH_CLEN = 3'd3,
    PH_CONT = 3'd4,
    PH_DEAD = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] section;
    logic       header_error;
    logic       entry_last;
  } result_t;

  typedef struct packed {
    logic       take;
    logic       stall;
  } hs_t;

  function automatic logic [31:0] key_next(input logic [31:0] k);
    return k * KEY_MUL + KEY_ADD;
  endfunction

  function automatic logic [7:0] key_byte(input logic [31:0] k, input logic [1:0] pos);
    return k[{pos, 3'b000} +: 8];
  endfunction

endpackage

>>> hw/rtl/xkac_engine.sv
// Archive state registers and the per-byte keystream step.
// Depends on xkac_pkg.
module xkac_engine (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   take_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   restart_i,
  input  logic [31:0]            initial_key_i,
  input  logic                   encode_mode_i,
  output xkac_pkg::result_t      res_o
);

  xkac_pkg::phase_e phase_q, phase_d;
  logic [31:0] main_key_q, main_key_d;
  logic [31:0] content_key_q, content_key_d;
  logic [2:0]  biw_q, biw_d;
  logic [23:0] acc_q, acc_d;
  logic [31:0] rem_q, rem_d;
  logic        bad_q, bad_d;

  // state as seen by this byte, after an optional restart
  xkac_pkg::phase_e e_phase;
  logic [31:0] e_main_key, e_content_key, e_rem;
  logic [2:0]  e_biw;
  logic [23:0] e_acc;
  logic        e_bad;

  logic [7:0]  hdr_exp;
  logic [7:0]  xored;
  logic [7:0]  plain;
  logic [7:0]  name_byte;
  logic [31:0] full_len;
  logic [31:0] rem_dec;

  always_comb begin
    e_phase       = restart_i ? xkac_pkg::PH_HDR : phase_q;
    e_main_key    = restart_i ? initial_key_i : main_key_q;
    e_content_key = restart_i ? '0 : content_key_q;
    e_biw         = restart_i ? '0 : biw_q;
    e_acc         = restart_i ? '0 : acc_q;
    e_rem         = restart_i ? '0 : rem_q;
    e_bad         = restart_i ? 1'b0 : bad_q;

    hdr_exp   = e_biw[2] ? xkac_pkg::key_byte(xkac_pkg::HDR_WORD1, e_biw[1:0])
                         : xkac_pkg::key_byte(xkac_pkg::HDR_WORD0, e_biw[1:0]);
    xored     = data_byte_i ^ xkac_pkg::key_byte(
                  (e_phase == xkac_pkg::PH_CONT) ? e_content_key : e_main_key, e_biw[1:0]);
    plain     = encode_mode_i ? data_byte_i : xored;
    full_len  = {plain, e_acc};
    rem_dec   = e_rem - 32'd1;
    name_byte = (encode_mode_i && data_byte_i == xkac_pkg::CHAR_SLASH) ?
                xkac_pkg::CHAR_BSLASH : data_byte_i;

    phase_d       = e_phase;
    main_key_d    = e_main_key;
    content_key_d = e_content_key;
    biw_d         = e_biw;
    acc_d         = e_acc;
    rem_d         = e_rem;
    bad_d         = e_bad;

    res_o = '{out_byte: data_byte_i, section: xkac_pkg::SEC_HDR,
              header_error: 1'b0, entry_last: 1'b0};

    unique case (e_phase)
      xkac_pkg::PH_HDR: begin
        bad_d = e_bad | (data_byte_i != hdr_exp);
        res_o.header_error = bad_d;
        if (e_biw == 3'd7) begin
          biw_d = '0;
          if (bad_d) begin
            phase_d = xkac_pkg::PH_DEAD;
          end else begin
            phase_d    = xkac_pkg::PH_NLEN;
            main_key_d = initial_key_i;
            acc_d      = '0;
          end
        end else begin
          biw_d = e_biw + 3'd1;
        end
      end
      xkac_pkg::PH_NLEN, xkac_pkg::PH_CLEN: begin
        res_o.section  = (e_phase == xkac_pkg::PH_NLEN) ? xkac_pkg::SEC_NLEN
                                                         : xkac_pkg::SEC_CLEN;
        res_o.out_byte = xored;
        if (e_biw[1:0] == 2'd3) begin
          biw_d      = '0;
          main_key_d = xkac_pkg::key_next(e_main_key);
          rem_d      = full_len;
          acc_d      = '0;
          if (e_phase == xkac_pkg::PH_NLEN) begin
            phase_d = (full_len != '0) ? xkac_pkg::PH_NAME : xkac_pkg::PH_CLEN;
          end else begin
            content_key_d = main_key_d;
            if (full_len != '0) begin
              phase_d = xkac_pkg::PH_CONT;
            end else begin
              phase_d = xkac_pkg::PH_NLEN;
              res_o.entry_last = 1'b1;
            end
          end
        end else begin
          acc_d[{e_biw[1:0], 3'b000} +: 8] = plain;
          biw_d = e_biw + 3'd1;
        end
      end
      xkac_pkg::PH_NAME: begin
        res_o.section  = xkac_pkg::SEC_NAME;
        res_o.out_byte = name_byte ^ e_main_key[7:0];
        main_key_d     = xkac_pkg::key_next(e_main_key);
        rem_d          = rem_dec;
        if (rem_dec == '0) begin
          phase_d = xkac_pkg::PH_CLEN;
          biw_d   = '0;
          acc_d   = '0;
        end
      end
      xkac_pkg::PH_CONT: begin
        res_o.section  = xkac_pkg::SEC_CONT;
        res_o.out_byte = xored;
        rem_d          = rem_dec;
        // step the word key at a word boundary or at the end of the content
        if (e_biw[1:0] == 2'd3 || rem_dec == '0) begin
          content_key_d = xkac_pkg::key_next(e_content_key);
          biw_d         = '0;
        end else begin
          biw_d = e_biw + 3'd1;
        end
        if (rem_dec == '0) begin
          phase_d = xkac_pkg::PH_NLEN;
          acc_d   = '0;
          res_o.entry_last = 1'b1;
        end
      end
      default: begin
        phase_d = xkac_pkg::PH_DEAD;
        res_o.header_error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= xkac_pkg::PH_HDR;
      main_key_q    <= xkac_pkg::KEY_RESET;
      content_key_q <= '0;
      biw_q         <= '0;
      acc_q         <= '0;
      rem_q         <= '0;
      bad_q         <= 1'b0;
    end else if (take_i) begin
      phase_q       <= phase_d;
      main_key_q    <= main_key_d;
      content_key_q <= content_key_d;
      biw_q         <= biw_d;
      acc_q         <= acc_d;
      rem_q         <= rem_d;
      bad_q         <= bad_d;
    end
  end

endmodule

>>> hw/rtl/xkac_out_reg.sv
// Result holding register with valid/stall handshake on both sides.
// Depends on xkac_pkg.
module xkac_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  xkac_pkg::result_t res_i,
  input  logic              out_stall_i,
  output xkac_pkg::hs_t     hs_o,
  output logic              out_valid_o,
  output xkac_pkg::result_t res_o
);

  logic              valid_q, valid_d;
  xkac_pkg::result_t res_q;

  always_comb begin
    // hold only while a beat sits here and the sink stalls
    hs_o.stall = valid_q & out_stall_i;
    hs_o.take  = in_valid_i & ~hs_o.stall;
    valid_d    = hs_o.take | hs_o.stall;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hs_o.take) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/xor_keystream_archive_codec.sv
// Keystream-XOR archive codec: one archive byte in, one processed byte out.
// Output: the result of an accepted byte is registered and held until the sink takes it.
// Throughput: one byte per cycle unless the sink stalls a held result; the key step
// (k*7+3) and the byte XOR settle in the accept cycle and load the result register.
// Reset: asynchronous, active low; the key register returns to 0xDEADCAFE, decode mode,
// header phase, and the result register empties.
module xor_keystream_archive_codec (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [xkac_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [xkac_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // archive byte input
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               restart_i,
  // processed byte output
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [7:0]                         out_byte_o,
  output logic [2:0]                         section_o,
  output logic                               header_error_o,
  output logic                               entry_last_o
);

  logic [31:0]       initial_key_q;
  logic              encode_mode_q;
  xkac_pkg::hs_t     hs;
  xkac_pkg::result_t step_res;
  xkac_pkg::result_t out_res;

  // Configuration registers. The key only matters on a restart and when a header completes,
  // the mode applies from the next accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      initial_key_q <= xkac_pkg::KEY_RESET;
      encode_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        xkac_pkg::CFG_INITIAL_KEY: initial_key_q <= cfg_data_i;
        xkac_pkg::CFG_ENCODE_MODE: encode_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Archive state and the per-beat transform; state advances only on accept.
  xkac_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .take_i        (hs.take),
    .data_byte_i   (data_byte_i),
    .restart_i     (restart_i),
    .initial_key_i (initial_key_q),
    .encode_mode_i (encode_mode_q),
    .res_o         (step_res)
  );

  // Result register: a new beat enters whenever the held one leaves or none is held.
  xkac_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .res_i       (step_res),
    .out_stall_i (out_stall_i),
    .hs_o        (hs),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign in_stall_o     = hs.stall;
  assign out_byte_o     = out_res.out_byte;
  assign section_o      = out_res.section;
  assign header_error_o = out_res.header_error;
  assign entry_last_o   = out_res.entry_last;

`ifndef SYNTHESIS
  a_stall_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no result held");

  a_accept_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> out_valid_o)
    else $error("accepted beat produced no result");

  a_err_only_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && section_o != xkac_pkg::SEC_HDR) |-> !header_error_o)
    else $error("header error flagged outside the header section");

  a_last_not_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_last_o) |->
      (section_o == xkac_pkg::SEC_CLEN || section_o == xkac_pkg::SEC_CONT))
    else $error("entry end flagged outside a length or content byte");
`endif

endmodule

>>> tb/sv/xor_keystream_archive_codec_test.sv
// Self-checking bench for xor_keystream_archive_codec: random archive streams,
// a bit-true byte predictor with a scoreboard, and random gaps and stalls.
// Depends on xkac_pkg and the codec RTL only.
module xor_keystream_archive_codec_test;
  timeunit 1ns;
  timeprecision 1ps;

  import xkac_pkg::*;

  // Track the archive stream and queue the result of every accepted input beat.
  class archive_scoreboard;
    logic [31:0] init_key;
    logic        enc_mode;
    phase_e      phase;
    logic [31:0] main_key;
    logic [31:0] content_key;
    logic [31:0] len_acc;
    logic [31:0] remaining;
    logic [2:0]  pos;
    logic        hdr_bad;
    result_t     expected_q[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      init_key = KEY_RESET;
      enc_mode = 1'b0;
      mismatches = 0;
      checked = 0;
      restart_stream();
    endfunction

    function void restart_stream();
      phase = PH_HDR;
      main_key = init_key;
      content_key = '0;
      len_acc = '0;
      remaining = '0;
      pos = '0;
      hdr_bad = 1'b0;
    endfunction

    function logic [31:0] advance_key(logic [31:0] k);
      return k * KEY_MUL + KEY_ADD;
    endfunction

    function logic [7:0] key_lane(logic [31:0] k, logic [1:0] p);
      return 8'(k >> (8 * p));
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_INITIAL_KEY: init_key = val;
        CFG_ENCODE_MODE: enc_mode = val[0];
        default: ;
      endcase
    endfunction

    // Byte to put on the wire so that the codec recovers plain length byte p.
    function logic [7:0] wire_len_byte(logic [31:0] len, logic [1:0] p);
      logic [7:0] plain;
      plain = 8'(len >> (8 * p));
      return enc_mode ? plain : plain ^ key_lane(main_key, p);
    endfunction

    function void note_byte(logic [7:0] b, logic rs);
      result_t     r;
      logic [63:0] sig;
      logic [31:0] plain;
      logic [7:0]  v;
      logic [2:0]  np;
      sig = {HDR_WORD1, HDR_WORD0};
      r = '0;
      r.out_byte = b;
      r.section = SEC_HDR;
      if (rs) restart_stream();
      case (phase)
        PH_HDR: begin
          if (b != sig[8 * pos +: 8]) hdr_bad = 1'b1;
          r.header_error = hdr_bad;
          if (pos == 3'd7) begin
            pos = '0;
            if (hdr_bad) begin
              phase = PH_DEAD;
            end else begin
              phase = PH_NLEN;
              main_key = init_key;
              len_acc = '0;
            end
          end else begin
            pos = pos + 3'd1;
          end
        end
        PH_NLEN, PH_CLEN: begin
          r.section = (phase == PH_NLEN) ? SEC_NLEN : SEC_CLEN;
          r.out_byte = b ^ key_lane(main_key, pos[1:0]);
          plain = enc_mode ? 32'(b) : 32'(r.out_byte);
          len_acc = len_acc | (plain << (8 * pos[1:0]));
          if (pos[1:0] == 2'd3) begin
            pos = '0;
            main_key = advance_key(main_key);
            remaining = len_acc;
            len_acc = '0;
            if (phase == PH_NLEN) begin
              phase = (remaining != 0) ? PH_NAME : PH_CLEN;
            end else begin
              content_key = main_key;
              if (remaining != 0) begin
                phase = PH_CONT;
              end else begin
                phase = PH_NLEN;
                r.entry_last = 1'b1;
              end
            end
          end else begin
            pos = 3'(pos[1:0]) + 3'd1;
          end
        end
        PH_NAME: begin
          r.section = SEC_NAME;
          v = (enc_mode && b == CHAR_SLASH) ? CHAR_BSLASH : b;
          r.out_byte = v ^ main_key[7:0];
          main_key = advance_key(main_key);
          remaining = remaining - 1;
          if (remaining == 0) begin
            phase = PH_CLEN;
            pos = '0;
            len_acc = '0;
          end
        end
        PH_CONT: begin
          r.section = SEC_CONT;
          r.out_byte = b ^ key_lane(content_key, pos[1:0]);
          np = 3'(pos[1:0]) + 3'd1;
          remaining = remaining - 1;
          if (np >= 3'd4 || remaining == 0) begin
            content_key = advance_key(content_key);
            np = '0;
          end
          pos = np;
          if (remaining == 0) begin
            phase = PH_NLEN;
            pos = '0;
            len_acc = '0;
            r.entry_last = 1'b1;
          end
        end
        default: begin
          // bad header: pass everything through flagged until a restart
          phase = PH_DEAD;
          r.header_error = 1'b1;
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void field_check(string what, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, exp_v, act_v);
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output beat %0h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      field_check("out_byte", exp_r.out_byte, got.out_byte);
      field_check("section", exp_r.section, got.section);
      field_check("header_error", exp_r.header_error, got.header_error);
      field_check("entry_last", exp_r.entry_last, got.entry_last);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void flag_leftovers();
      if (expected_q.size() != 0) begin
        mismatches += expected_q.size();
        $display("%0t: %0d expected output beats never arrived", $time, expected_q.size());
      end
    endfunction
  endclass

  localparam int unsigned BYTES_PER_SETTING = 110;
  localparam int unsigned SETTINGS_RUN = 8;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [7:0] data_byte_i;
  logic restart_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic [2:0] section_o;
  logic header_error_o;
  logic entry_last_o;

  archive_scoreboard sb;
  int unsigned gap_pct = 0;    // chance per cycle that the sender holds off
  int unsigned stall_pct = 0;  // chance per cycle that the receiver stalls
  int unsigned items = 0;
  int unsigned archives = 0;
  int unsigned entries = 0;
  int unsigned bad_headers = 0;

  xor_keystream_archive_codec uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .section_o      (section_o),
    .header_error_o (header_error_o),
    .entry_last_o   (entry_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver: draw a new stall each falling edge, take beats at the rising edge.
  always @(negedge clk_i) out_stall_i <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result({out_byte_o, section_o, header_error_o, entry_last_o});
  end

  // Drive one input beat. Enter and leave at a falling edge; hold the payload
  // until the codec takes it, then hand it to the predictor.
  task automatic send_byte(logic [7:0] b, logic rs);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    restart_i <= rs;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(b, rs);
    items++;
    @(negedge clk_i);
  endtask

  // Write one register; only called with the codec drained.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    sb.set_register(idx, val);
  endtask

  // Drop input valid, wait for every queued result, then let the pipe settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  // Send the first nbytes of the signature, corrupting byte bad_pos if below 8.
  task automatic send_header(logic rs, int unsigned bad_pos, int unsigned nbytes);
    logic [63:0] sig;
    logic [7:0]  b;
    sig = {HDR_WORD1, HDR_WORD0};
    archives++;
    for (int unsigned p = 0; p < nbytes; p++) begin
      b = sig[8 * p +: 8];
      if (p == bad_pos) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b, (p == 0) ? rs : 1'b0);
    end
  endtask

  // The wire bytes depend on the predictor's key at the moment each one is made.
  task automatic send_length(logic [31:0] len);
    for (int p = 0; p < 4; p++) send_byte(sb.wire_len_byte(len, 2'(p)), 1'b0);
  endtask

  // Send one entry; stop after cap name or content bytes to leave it broken.
  task automatic send_entry(logic [31:0] nlen, logic [31:0] clen, logic [31:0] cap);
    send_length(nlen);
    for (int unsigned i = 0; i < nlen && i < cap; i++)
      send_byte(($urandom_range(0, 3) == 0) ? CHAR_SLASH : 8'($urandom), 1'b0);
    if (nlen > cap) return;
    send_length(clen);
    for (int unsigned i = 0; i < clen && i < cap; i++) send_byte(8'($urandom), 1'b0);
    if (clen > cap) return;
    entries++;
  endtask

  // Mostly well-formed archives with random content; now and then noise,
  // a bad or cut header, or an entry whose huge length is cut by a restart.
  task automatic send_random_archive();
    int unsigned bad_pos;
    int unsigned cut;
    int unsigned n_ent;
    logic [31:0] nlen;
    logic [31:0] clen;
    logic [31:0] huge;
    logic        rs;
    if ($urandom_range(0, 15) == 0) begin
      repeat ($urandom_range(1, 12))
        send_byte(8'($urandom), ($urandom_range(0, 15) == 0));
      return;
    end
    // Sometimes keep appending entries to the open archive, across a config change.
    if (!(sb.phase == PH_NLEN && $urandom_range(0, 3) == 0)) begin
      rs = (sb.phase != PH_HDR || sb.pos != 0) ? 1'b1 : 1'($urandom_range(0, 1));
      bad_pos = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : 8;
      cut = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 7) : 8;
      send_header(rs, bad_pos, cut);
      if (cut < 8) return;
      if (bad_pos < 8) begin
        bad_headers++;
        repeat ($urandom_range(0, 6)) send_byte(8'($urandom), 1'b0);
        return;
      end
    end
    n_ent = $urandom_range(1, 4);
    for (int unsigned e = 0; e < n_ent; e++) begin
      nlen = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 10));
      clen = ($urandom_range(0, 4) == 0) ? 32'd0 : 32'($urandom_range(1, 20));
      if ($urandom_range(0, 15) == 0) begin
        huge = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
        if ($urandom_range(0, 1)) nlen = huge;
        else clen = huge;
        send_entry(nlen, clen, 32'($urandom_range(0, 6)));
        return;
      end
      send_entry(nlen, clen, 32'hFFFF_FFFF);
    end
  endtask

  initial begin
    int unsigned goal;
    logic [31:0] key;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_INITIAL_KEY;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    restart_i = 1'b0;
    sb = new();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset key and decode mode. A header bad in its last byte,
    // dead-state bytes at both extremes, then a restart into a good header,
    // one entry with a one-byte name and empty content.
    send_header(1'b0, 7, 8);
    bad_headers++;
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_header(1'b1, 8, 8);
    send_entry(32'd1, 32'd0, 32'hFFFF_FFFF);

    // Random: walk through key and mode settings, extremes first, and rotate
    // the idling pattern: none, sender gaps, receiver stalls, both.
    for (int unsigned s = 0; s < SETTINGS_RUN; s++) begin
      drain();
      gap_pct = 0;
      stall_pct = 0;
      key = (s == 0) ? 32'h0 : (s == 1) ? 32'hFFFF_FFFF : $urandom;
      cfg_write(CFG_INITIAL_KEY, key);
      cfg_write(CFG_ENCODE_MODE, 32'(s % 2));
      case (s % 4)
        1: gap_pct = 53;
        2: stall_pct = 53;
        3: begin
          gap_pct = 34;
          stall_pct = 34;
        end
        default: ;
      endcase
      goal = items + BYTES_PER_SETTING;
      while (items < goal) send_random_archive();
    end
    in_valid_i <= 1'b0;

    // Let the last results through, bounded in case the output never drains.
    for (int n = 0; n < 20000 && sb.pending() != 0; n++) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    sb.flag_leftovers();

    $display("Sent %0d bytes: %0d archives, %0d complete entries, %0d bad headers,",
             items, archives, entries, bad_headers);
    $display("across %0d key/mode settings; %0d output beats checked, %0d mismatches.",
             SETTINGS_RUN, sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2ms;
    $display("%0t: timeout, stream did not finish", $time);
    $display("Test completed with failures");
    $finish;
  end

endmodule
